FILE: sv/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and constants of the CAN mailbox manager
// Transfer payloads, operation and register codes, status bit masks and the
// controller state type.
// ----------------------------------------------------------------------------
package cmm_pkg;

    // Object index width and the "no object" code
    localparam int          IDX_W     = 4;
    localparam int          MAP_W     = 15;
    localparam logic [3:0]  NO_OBJECT = 4'd15;

    // Event status bits
    localparam logic [6:0]  ST_ERR_MASK = 7'h17;   // ack, form, crc, bit error
    localparam logic [6:0]  ST_RX_OK    = 7'h20;
    localparam logic [6:0]  ST_TX_OK    = 7'h40;

    // Global interrupt enable bits
    localparam logic [7:0]  GIE_ALL = 8'h80;
    localparam logic [7:0]  GIE_ERR = 8'h08;
    localparam logic [7:0]  GIE_RX  = 8'h20;
    localparam logic [7:0]  GIE_TX  = 8'h10;

    // Configuration register reset values
    localparam logic [3:0]  TX_FIRST_RST = 4'd0;
    localparam logic [3:0]  TX_LAST_RST  = 4'd7;
    localparam logic [3:0]  RX_FIRST_RST = 4'd8;
    localparam logic [3:0]  RX_LAST_RST  = 4'd14;
    localparam logic [14:0] IRQ_MASK_RST = 15'h7fff;
    localparam logic [7:0]  GIE_RST      = 8'h80;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_EVENT   = 2'd1,
        OP_READ_RX = 2'd2,
        OP_ARM_RX  = 2'd3
    } op_mode_t;

    typedef enum logic [1:0] {
        OBJ_DISABLED = 2'd0,
        OBJ_TRANSMIT = 2'd1,
        OBJ_RECEIVE  = 2'd2,
        OBJ_FRAME_RX = 2'd3
    } obj_mode_t;

    typedef enum logic [2:0] {
        CFG_TX_FIRST = 3'd0,
        CFG_TX_LAST  = 3'd1,
        CFG_RX_FIRST = 3'd2,
        CFG_RX_LAST  = 3'd3,
        CFG_IRQ_MASK = 3'd4,
        CFG_GIE      = 3'd5
    } cfg_idx_t;

    typedef enum logic [0:0] {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] object_index;
        logic [6:0] event_status;
        logic [3:0] arm_count;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  result_object;
        logic        success;
        logic [14:0] rx_full_map;
        logic        all_rx_full;
        logic [3:0]  tx_error_object;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the input transfer
        logic exec;      // evaluate, commit state and load the result register
    } cmm_cmd_t;

    // Number of set bits in a 15-bit map: five groups of three, then summed
    function automatic logic [3:0] count15(input logic [14:0] v);
        logic [3:0] sum;
        logic [3:0] grp;
        sum = 4'd0;
        for (int g = 0; g < 5; g++)
        begin
            grp = 4'(v[3*g]) + 4'(v[3*g+1]) + 4'(v[3*g+2]);
            sum = sum + grp;
        end
        return sum;
    endfunction

endpackage

FILE: sv/cmm_ctrl.sv
// ----------------------------------------------------------------------------
// cmm_ctrl: sequencing controller of the CAN mailbox manager
// Captures one input transfer, runs the evaluate-and-commit cycle once the
// result register is free, and keeps the output valid flag.
// ----------------------------------------------------------------------------
module cmm_ctrl
    import cmm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output cmm_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State and output flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                // commit only when the result register is empty or draining
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Result flag: set by a commit, cleared by a taken transfer
    always_comb
    begin
        priority if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // a commit always leaves a result on offer
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("commit did not raise out_valid");

    // only one item in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && state_reg == CTL_EXEC))
        else $error("second item taken while one is in work");
`endif

endmodule

FILE: sv/cmm_datapath.sv
// ----------------------------------------------------------------------------
// cmm_datapath: object state and operation logic of the CAN mailbox manager
// Holds configuration, object modes, the receive-full map and flags, and
// evaluates one operation over all objects in the commit cycle.
// ----------------------------------------------------------------------------
module cmm_datapath
    import cmm_pkg::*;
#(
    parameter int OBJECT_COUNT = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  in_item_t    in_data,
    input  cmm_cmd_t    cmd,
    output out_item_t   out_data
);

    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(OBJECT_COUNT - 1);
    localparam logic [OBJECT_COUNT-1:0] ALL_OBJ  = {OBJECT_COUNT{1'b1}};

    // Configuration registers
    logic [3:0]  tx_first_reg, tx_last_reg, rx_first_reg, rx_last_reg;
    logic [14:0] irq_mask_reg;
    logic [7:0]  gie_reg;

    // Object state
    obj_mode_t               mode_reg [OBJECT_COUNT];
    obj_mode_t               mode_next [OBJECT_COUNT];
    logic [OBJECT_COUNT-1:0] rx_full_reg, rx_full_next;
    logic                    buf_full_reg, buf_full_next;
    logic [IDX_W-1:0]        tx_err_reg, tx_err_next;

    // Captured input and result register
    in_item_t  in_reg;
    out_item_t out_reg, out_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_first_reg <= TX_FIRST_RST;
            tx_last_reg  <= TX_LAST_RST;
            rx_first_reg <= RX_FIRST_RST;
            rx_last_reg  <= RX_LAST_RST;
            irq_mask_reg <= IRQ_MASK_RST;
            gie_reg      <= GIE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TX_FIRST: tx_first_reg <= cfg_data[3:0];
                CFG_TX_LAST:  tx_last_reg  <= cfg_data[3:0];
                CFG_RX_FIRST: rx_first_reg <= cfg_data[3:0];
                CFG_RX_LAST:  rx_last_reg  <= cfg_data[3:0];
                CFG_IRQ_MASK: irq_mask_reg <= cfg_data;
                CFG_GIE:      gie_reg      <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Input capture and result register (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        if (cmd.exec)
            out_reg <= out_next;
    end

    // Object state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OBJECT_COUNT; i++)
                mode_reg[i] <= OBJ_DISABLED;
            rx_full_reg  <= '0;
            buf_full_reg <= 1'b0;
            tx_err_reg   <= NO_OBJECT;
        end
        else if (cmd.exec)
        begin
            for (int i = 0; i < OBJECT_COUNT; i++)
                mode_reg[i] <= mode_next[i];
            rx_full_reg  <= rx_full_next;
            buf_full_reg <= buf_full_next;
            tx_err_reg   <= tx_err_next;
        end
    end

    // Evaluation signals
    logic [IDX_W-1:0]        tf, tl, rf, rl;
    logic [OBJECT_COUNT-1:0] tx_range, rx_range, free_map;
    logic [OBJECT_COUNT-1:0] alloc_cand, read_cand, arm_free, arm_sel;
    logic [OBJECT_COUNT-1:0] pick_cand, pick_hot, obj_hot;
    logic [OBJECT_COUNT-1:0] set_tx, set_rx, clr_obj;
    logic [IDX_W-1:0]        pick_idx, arm_total, prefix;
    logic                    ev_hit, ev_in_tx, all_en, err_en, rx_en, tx_en;
    logic [IDX_W-1:0]        obj;
    logic [6:0]              st;

    // Range masks, free map and candidate maps
    always_comb
    begin
        tf = (tx_first_reg > LAST_IDX) ? LAST_IDX : tx_first_reg;
        tl = (tx_last_reg  > LAST_IDX) ? LAST_IDX : tx_last_reg;
        rf = (rx_first_reg > LAST_IDX) ? LAST_IDX : rx_first_reg;
        rl = (rx_last_reg  > LAST_IDX) ? LAST_IDX : rx_last_reg;
        for (int i = 0; i < OBJECT_COUNT; i++)
        begin
            tx_range[i] = (IDX_W'(i) >= tf) && (IDX_W'(i) <= tl);
            rx_range[i] = (IDX_W'(i) >= rf) && (IDX_W'(i) <= rl);
            free_map[i] = (mode_reg[i] == OBJ_DISABLED);
        end
        alloc_cand = free_map & tx_range;
        read_cand  = rx_full_reg & rx_range;
        arm_free   = free_map & rx_range;
    end

    // Lowest candidate: isolate the lowest set bit, then encode it
    always_comb
    begin
        pick_cand = (op_mode_t'(in_reg.mode) == OP_ALLOC) ? alloc_cand : read_cand;
        pick_hot  = pick_cand & (~pick_cand + OBJECT_COUNT'(1));
        pick_idx  = '0;
        for (int i = 0; i < OBJECT_COUNT; i++)
            if (pick_hot[i])
                pick_idx = pick_idx | IDX_W'(i);
    end

    // Receiver arming: an object is armed if fewer than arm_count free ones lie below it
    always_comb
    begin
        arm_total = count15(MAP_W'(arm_free));
        prefix    = '0;
        for (int i = 0; i < OBJECT_COUNT; i++)
        begin
            prefix     = count15(MAP_W'(arm_free & (ALL_OBJ >> (OBJECT_COUNT - i))));
            arm_sel[i] = arm_free[i] && (prefix < in_reg.arm_count);
        end
    end

    // Operation decode and next state
    always_comb
    begin
        obj      = in_reg.object_index;
        st       = in_reg.event_status;
        obj_hot  = OBJECT_COUNT'(1) << obj;
        ev_hit   = (obj <= LAST_IDX) && irq_mask_reg[obj];
        ev_in_tx = (obj >= tf) && (obj <= tl);
        all_en   = (gie_reg & GIE_ALL) != '0;
        err_en   = all_en || ((gie_reg & GIE_ERR) != '0);
        rx_en    = all_en || ((gie_reg & GIE_RX) != '0);
        tx_en    = all_en || ((gie_reg & GIE_TX) != '0);

        set_tx        = '0;
        set_rx        = '0;
        clr_obj       = '0;
        rx_full_next  = rx_full_reg;
        buf_full_next = buf_full_reg;
        tx_err_next   = tx_err_reg;
        out_next.result_object = NO_OBJECT;
        out_next.success       = 1'b0;

        unique case (op_mode_t'(in_reg.mode))
            OP_ALLOC:
            begin
                if (|alloc_cand)
                begin
                    set_tx                 = pick_hot;
                    out_next.result_object = pick_idx;
                    out_next.success       = 1'b1;
                end
            end
            OP_EVENT:
            begin
                if (ev_hit)
                begin
                    out_next.result_object = obj;
                    out_next.success       = 1'b1;
                    // stuff errors are not recorded
                    if (err_en && ((st & ST_ERR_MASK) != '0) && ev_in_tx)
                        tx_err_next = obj;
                    if (rx_en && ((st & ST_RX_OK) != '0))
                    begin
                        rx_full_next = rx_full_reg | obj_hot;
                        clr_obj      = obj_hot;
                        if (rx_full_next == ALL_OBJ)
                            buf_full_next = 1'b1;
                    end
                    if (tx_en && ((st & ST_TX_OK) != '0))
                        clr_obj = obj_hot;
                end
            end
            OP_READ_RX:
            begin
                if (|read_cand)
                begin
                    rx_full_next           = rx_full_reg & ~pick_hot;
                    set_rx                 = pick_hot;
                    buf_full_next          = 1'b0;
                    out_next.result_object = pick_idx;
                    out_next.success       = 1'b1;
                end
            end
            OP_ARM_RX:
            begin
                if (arm_total >= in_reg.arm_count)
                begin
                    set_rx           = arm_sel;
                    out_next.success = 1'b1;
                end
            end
            default:
            begin
                out_next.success = 1'b0;
            end
        endcase

        for (int i = 0; i < OBJECT_COUNT; i++)
        begin
            priority if (clr_obj[i])
                mode_next[i] = OBJ_DISABLED;
            else if (set_rx[i])
                mode_next[i] = OBJ_RECEIVE;
            else if (set_tx[i])
                mode_next[i] = OBJ_TRANSMIT;
            else
                mode_next[i] = mode_reg[i];
        end

        out_next.rx_full_map     = MAP_W'(rx_full_next);
        out_next.all_rx_full     = buf_full_next;
        out_next.tx_error_object = tx_err_next;
    end

    assign out_data = out_reg;

`ifndef SYNTH
    // the full flag tracks a completely set receive map
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full_reg == (rx_full_reg == ALL_OBJ))
        else $error("buffers-full flag out of step with receive map");

    // object state changes only in the commit cycle
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(rx_full_reg) && $stable(tx_err_reg)))
        else $error("object state changed outside a commit");
`endif

endmodule

FILE: sv/can_mailbox_manager.sv
// ----------------------------------------------------------------------------
// can_mailbox_manager: CAN message object mailbox manager
// Keeps the mode of each message object and the receive-full map; allocates
// transmit objects, applies status events, reads and re-arms receivers.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | handshake
//  --------+----------------------------------+-----------+------------------
//  in      | in_valid, in_ready, in_data      | in        | valid / ready
//  out     | out_valid, out_ready, out_data   | out       | valid / ready
//  cfg     | cfg_we, cfg_index, cfg_data      | in        | write enable only
//
//  Each item is first captured from the input transfer; the datapath then
//  evaluates the operation over all objects and commits it.
//  One item is in work at a time; the next is taken while the result waits.
//  A result not yet taken holds only the commit cycle of the following item.
//  Reset (rst_n, asynchronous) returns configuration to its defaults, all
//  objects to disabled, clears the receive map and sets no transmit error.
// ----------------------------------------------------------------------------
module can_mailbox_manager
    import cmm_pkg::*;
#(
    parameter int OBJECT_COUNT = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    cmm_cmd_t cmd;

    // Sequencing
    cmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Object state and operations
    cmm_datapath #(
        .OBJECT_COUNT (OBJECT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule

FILE: bench/can_mailbox_manager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_mailbox_manager_tb: self-checking bench for the CAN mailbox manager
// Drives operation transfers through the valid/ready input channel and keeps
// its own model of the object modes, receive-full map and transmit error
// object. Every result transfer is checked against the oldest prediction.
// Directed tests cover each operation and its corner cases. Random traffic
// then mixes allocate, receive and flood sequences with noise, under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
module can_mailbox_manager_tb;
    import cmm_pkg::*;

    localparam int OBJECT_COUNT = 15;
    localparam int LAST_OBJ     = OBJECT_COUNT - 1;
    localparam int QUIET_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    // Model state and register copies
    obj_mode_t   obj_state [OBJECT_COUNT];
    logic [14:0] rx_full;
    logic        full_flag;
    logic [3:0]  tx_err_obj;
    logic [3:0]  r_tx_first;
    logic [3:0]  r_tx_last;
    logic [3:0]  r_rx_first;
    logic [3:0]  r_rx_last;
    logic [14:0] r_irq_mask;
    logic [7:0]  r_gie;

    out_item_t   pending_results [$];
    int          error_count;
    int          sent_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    can_mailbox_manager #(
        .OBJECT_COUNT (OBJECT_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Range bounds beyond the last object are clipped to it
    function automatic int clip_bound(logic [3:0] v);
        return (int'(v) > LAST_OBJ) ? LAST_OBJ : int'(v);
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < OBJECT_COUNT; i++)
            obj_state[i] = OBJ_DISABLED;
        rx_full    = '0;
        full_flag  = 1'b0;
        tx_err_obj = NO_OBJECT;
        r_tx_first = TX_FIRST_RST;
        r_tx_last  = TX_LAST_RST;
        r_rx_first = RX_FIRST_RST;
        r_rx_last  = RX_LAST_RST;
        r_irq_mask = IRQ_MASK_RST;
        r_gie      = GIE_RST;
    endfunction

    // Applies one operation to the model and returns the result it gives
    function automatic out_item_t mailbox_step(in_item_t it);
        out_item_t r;
        int        tf;
        int        tl;
        int        rf;
        int        rl;
        int        free_cnt;
        int        armed;
        logic      found;
        logic      all_en;
        r.result_object = NO_OBJECT;
        r.success       = 1'b0;
        tf    = clip_bound(r_tx_first);
        tl    = clip_bound(r_tx_last);
        rf    = clip_bound(r_rx_first);
        rl    = clip_bound(r_rx_last);
        found = 1'b0;
        case (it.mode)
            OP_ALLOC:
            begin
                for (int i = tf; i <= tl; i++)
                begin
                    if (!found && obj_state[i] == OBJ_DISABLED)
                    begin
                        obj_state[i]    = OBJ_TRANSMIT;
                        r.result_object = 4'(i);
                        r.success       = 1'b1;
                        found           = 1'b1;
                    end
                end
            end
            OP_EVENT:
            begin
                if (int'(it.object_index) < OBJECT_COUNT && r_irq_mask[it.object_index])
                begin
                    all_en          = (r_gie & GIE_ALL) != 0;
                    r.result_object = it.object_index;
                    r.success       = 1'b1;
                    // stuff errors are not recorded
                    if ((all_en || (r_gie & GIE_ERR) != 0)
                        && (it.event_status & ST_ERR_MASK) != 0
                        && int'(it.object_index) >= tf && int'(it.object_index) <= tl)
                        tx_err_obj = it.object_index;
                    if ((all_en || (r_gie & GIE_RX) != 0) && (it.event_status & ST_RX_OK) != 0)
                    begin
                        rx_full = rx_full | (15'd1 << it.object_index);
                        obj_state[it.object_index] = OBJ_DISABLED;
                        if (rx_full == 15'h7fff)
                            full_flag = 1'b1;
                    end
                    if ((all_en || (r_gie & GIE_TX) != 0) && (it.event_status & ST_TX_OK) != 0)
                        obj_state[it.object_index] = OBJ_DISABLED;
                end
            end
            OP_READ_RX:
            begin
                for (int i = rf; i <= rl; i++)
                begin
                    if (!found && rx_full[i])
                    begin
                        rx_full[i]      = 1'b0;
                        obj_state[i]    = OBJ_RECEIVE;
                        full_flag       = 1'b0;
                        r.result_object = 4'(i);
                        r.success       = 1'b1;
                        found           = 1'b1;
                    end
                end
            end
            default:
            begin
                // arm only when enough free receivers exist
                free_cnt = 0;
                for (int i = rf; i <= rl; i++)
                    if (obj_state[i] == OBJ_DISABLED)
                        free_cnt++;
                if (free_cnt >= int'(it.arm_count))
                begin
                    armed = 0;
                    for (int i = rf; i <= rl; i++)
                    begin
                        if (armed < int'(it.arm_count) && obj_state[i] == OBJ_DISABLED)
                        begin
                            obj_state[i] = OBJ_RECEIVE;
                            armed++;
                        end
                    end
                    r.success = 1'b1;
                end
            end
        endcase
        r.rx_full_map     = rx_full;
        r.all_rx_full     = full_flag;
        r.tx_error_object = tx_err_obj;
        return r;
    endfunction

    function automatic in_item_t make_item(op_mode_t mode, int obj, int st, int cnt);
        in_item_t it;
        it.mode         = mode;
        it.object_index = 4'(obj);
        it.event_status = 7'(st);
        it.arm_count    = 4'(cnt);
        return it;
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        $display("cmm_tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    // Presents one item and records its prediction once the transfer happens
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(mailbox_step(it));
        sent_count++;
    endtask

    // Drops valid and waits for all results plus a little settling time
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [14:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_TX_FIRST: r_tx_first = value[3:0];
            CFG_TX_LAST:  r_tx_last  = value[3:0];
            CFG_RX_FIRST: r_rx_first = value[3:0];
            CFG_RX_LAST:  r_rx_last  = value[3:0];
            CFG_IRQ_MASK: r_irq_mask = value;
            CFG_GIE:      r_gie      = value[7:0];
            default:      ;
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = out_data;
            if (pending_results.size() == 0)
                note_mismatch("result transfer with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                if (got.result_object !== want.result_object)
                    note_mismatch($sformatf("result_object %0d, want %0d",
                                            got.result_object, want.result_object));
                if (got.success !== want.success)
                    note_mismatch($sformatf("success %0b, want %0b",
                                            got.success, want.success));
                if (got.rx_full_map !== want.rx_full_map)
                    note_mismatch($sformatf("rx_full_map %h, want %h",
                                            got.rx_full_map, want.rx_full_map));
                if (got.all_rx_full !== want.all_rx_full)
                    note_mismatch($sformatf("all_rx_full %0b, want %0b",
                                            got.all_rx_full, want.all_rx_full));
                if (got.tx_error_object !== want.tx_error_object)
                    note_mismatch($sformatf("tx_error_object %0d, want %0d",
                                            got.tx_error_object, want.tx_error_object));
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[can_mailbox_manager] ERROR");
            $finish;
        end
    end

    // Allocation, empty and clipped transmit ranges
    task automatic test_alloc_tx();
        send_item(make_item(OP_ALLOC, 0, 0, 0));
        send_item(make_item(OP_ALLOC, 0, 0, 0));
        wait_idle();
        write_reg(CFG_TX_FIRST, 15'd5);
        write_reg(CFG_TX_LAST, 15'd2);
        send_item(make_item(OP_ALLOC, 0, 0, 0));
        wait_idle();
        write_reg(CFG_TX_FIRST, 15'h7fff);
        write_reg(CFG_TX_LAST, 15'd15);
        send_item(make_item(OP_ALLOC, 0, 0, 0));
        send_item(make_item(OP_ALLOC, 0, 0, 0));
        wait_idle();
        write_reg(CFG_TX_FIRST, 15'd0);
        write_reg(CFG_TX_LAST, 15'd7);
    endtask

    // Status events: error recording, stuff error, masking and enable gating
    task automatic test_status_events();
        send_item(make_item(OP_EVENT, 0, 'h01, 0));
        send_item(make_item(OP_EVENT, 1, 'h08, 0));
        send_item(make_item(OP_EVENT, 1, 'h02, 0));
        send_item(make_item(OP_EVENT, 9, 'h04, 0));
        send_item(make_item(OP_EVENT, 0, ST_TX_OK, 0));
        send_item(make_item(OP_EVENT, 15, 'h7f, 15));
        wait_idle();
        write_reg(CFG_IRQ_MASK, 15'h7ffe);
        write_reg(CFG_GIE, 15'h0000);
        send_item(make_item(OP_EVENT, 0, 'h7f, 0));
        send_item(make_item(OP_EVENT, 1, 'h7f, 0));
        wait_idle();
        write_reg(CFG_GIE, 15'(GIE_ERR));
        send_item(make_item(OP_EVENT, 2, 'h10, 0));
        wait_idle();
        write_reg(CFG_GIE, 15'(GIE_RX | GIE_TX));
        send_item(make_item(OP_EVENT, 1, ST_RX_OK | ST_TX_OK, 0));
        wait_idle();
        write_reg(CFG_IRQ_MASK, 15'h7fff);
        write_reg(CFG_GIE, 15'h7f80);
    endtask

    // Reads: a full bit outside the range only, then two in range
    task automatic test_read_rx();
        send_item(make_item(OP_READ_RX, 0, 0, 0));
        send_item(make_item(OP_EVENT, 12, ST_RX_OK, 0));
        send_item(make_item(OP_EVENT, 9, ST_RX_OK, 0));
        send_item(make_item(OP_READ_RX, 0, 0, 0));
        send_item(make_item(OP_READ_RX, 0, 0, 0));
        send_item(make_item(OP_READ_RX, 0, 0, 0));
    endtask

    // Arming: zero count, more than the range holds, exactly the free ones
    task automatic test_arm_rx();
        send_item(make_item(OP_ARM_RX, 0, 0, 0));
        send_item(make_item(OP_ARM_RX, 0, 0, 15));
        send_item(make_item(OP_ARM_RX, 0, 0, 5));
        wait_idle();
    endtask

    function automatic int pick_in(logic [3:0] lo, logic [3:0] hi);
        int a;
        int b;
        a = clip_bound(lo);
        b = clip_bound(hi);
        if (a > b)
            return $urandom_range(0, LAST_OBJ);
        return $urandom_range(b, a);
    endfunction

    // New register setting; upper data bits beyond each register are noise
    task automatic random_config();
        int split;
        int pick;
        logic [14:0] mask;
        logic [7:0]  gie;
        if ($urandom_range(0, 1) == 0)
        begin
            split = $urandom_range(1, LAST_OBJ);
            write_reg(CFG_TX_FIRST, 15'({$urandom_range(0, 2047), 4'd0}));
            write_reg(CFG_TX_LAST, 15'(split - 1));
            write_reg(CFG_RX_FIRST, 15'(split));
            write_reg(CFG_RX_LAST, 15'($urandom_range(14, 15)));
        end
        else
        begin
            write_reg(CFG_TX_FIRST, 15'($urandom_range(0, 32767)));
            write_reg(CFG_TX_LAST, 15'($urandom_range(0, 32767)));
            write_reg(CFG_RX_FIRST, 15'($urandom_range(0, 32767)));
            write_reg(CFG_RX_LAST, 15'($urandom_range(0, 32767)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
            mask = 15'h7fff;
        else if (pick == 6)
            mask = 15'h0000;
        else
            mask = 15'($urandom_range(0, 32767));
        write_reg(CFG_IRQ_MASK, mask);
        case ($urandom_range(0, 4))
            0:       gie = GIE_ALL;
            1:       gie = 8'h00;
            2:       gie = 8'hff;
            3:       gie = GIE_ERR | GIE_RX | GIE_TX;
            default: gie = 8'($urandom_range(0, 255));
        endcase
        write_reg(CFG_GIE, {7'($urandom_range(0, 127)), gie});
    endtask

    // Random sequences until the block has taken n_items more items
    task automatic random_block(input int n_items);
        int target;
        int k;
        int st;
        int tmp;
        int j;
        int slots [OBJECT_COUNT];
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                // transmit flow: allocate, then errors and completions
                repeat ($urandom_range(1, 4))
                    send_item(make_item(OP_ALLOC, $urandom_range(0, 15),
                                        $urandom_range(0, 127), $urandom_range(0, 15)));
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0:       st = ST_TX_OK;
                        1:       st = 1 << $urandom_range(0, 4);
                        2:       st = $urandom_range(0, 127);
                        default: st = ST_TX_OK | (1 << $urandom_range(0, 4));
                    endcase
                    send_item(make_item(OP_EVENT, pick_in(r_tx_first, r_tx_last), st,
                                        $urandom_range(0, 15)));
                end
            end
            else if (k < 65)
            begin
                // receive flow: arm, receptions, reads
                send_item(make_item(OP_ARM_RX, $urandom_range(0, 15), $urandom_range(0, 127),
                                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 4)));
                repeat ($urandom_range(1, 4))
                    send_item(make_item(OP_EVENT, pick_in(r_rx_first, r_rx_last),
                                        ST_RX_OK | ($urandom_range(0, 3) == 0 ?
                                                    $urandom_range(0, 127) : 0),
                                        $urandom_range(0, 15)));
                repeat ($urandom_range(1, 4))
                    send_item(make_item(OP_READ_RX, $urandom_range(0, 15),
                                        $urandom_range(0, 127), $urandom_range(0, 15)));
            end
            else if (k < 75)
            begin
                // flood: a reception on every object in shuffled order
                for (int i = 0; i < OBJECT_COUNT; i++)
                    slots[i] = i;
                for (int i = LAST_OBJ; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    tmp      = slots[i];
                    slots[i] = slots[j];
                    slots[j] = tmp;
                end
                for (int i = 0; i < OBJECT_COUNT; i++)
                    send_item(make_item(OP_EVENT, slots[i], ST_RX_OK, $urandom_range(0, 15)));
                repeat ($urandom_range(1, 16))
                    send_item(make_item(OP_READ_RX, 0, 0, 0));
            end
            else
            begin
                // noise
                send_item(make_item(op_mode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                                    $urandom_range(0, 127), $urandom_range(0, 15)));
            end
        end
    endtask

    // Three idle patterns, each over several register settings
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 52;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 20;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                wait_idle();
                random_config();
                random_block(165);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_TX_FIRST;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        error_count    = 0;
        sent_count     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 52;
        model_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_alloc_tx();
        test_status_events();
        test_read_rx();
        test_arm_rx();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[can_mailbox_manager] OK");
        else
            $display("[can_mailbox_manager] ERROR");
        $finish;
    end

endmodule
